// ----- hdl/i2c_master_transaction_engine_core_assert.svh -----
// ----------------------------------------------------------------------------
// I2C master transaction engine assertion macros
// Shared concurrent assertion forms, sampled on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_TRANSACTION_ENGINE_CORE_ASSERT_SVH
`define I2C_MASTER_TRANSACTION_ENGINE_CORE_ASSERT_SVH

// same-cycle implication
`define I2C_MTE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2c_mte: assertion failed");

// next-cycle implication
`define I2C_MTE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2c_mte: assertion failed");

`endif

// ----- hdl/i2c_mte_pkg.sv -----
// ----------------------------------------------------------------------------
// I2C master transaction engine package
// Shared constants, codes and transaction types.
// ----------------------------------------------------------------------------
package i2c_mte_pkg;

    localparam int MAX_BYTES = 16;
    localparam int BUF_AW    = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);
    localparam int CMP_W     = (CNT_W > 5) ? CNT_W : 5;

    localparam logic [15:0] HPT_RESET     = 16'd5;
    localparam logic [7:0]  ADDR_WR_MASK  = 8'hFE;
    localparam logic [7:0]  ADDR_RD_BIT   = 8'h01;
    localparam logic [3:0]  BITS_PER_BYTE = 4'd8;

    // action codes
    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    // transfer kinds
    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_MEM_WR = 2'd2;
    localparam logic [1:0] KIND_MEM_RD = 2'd3;

    typedef enum logic [6:0] {
        PH_IDLE  = 7'b0000001,
        PH_START = 7'b0000010,
        PH_SEND  = 7'b0000100,
        PH_RDACK = 7'b0001000,
        PH_READ  = 7'b0010000,
        PH_SACK  = 7'b0100000,
        PH_STOP  = 7'b1000000
    } phase_t;

    typedef enum logic [6:0] {
        ST_DEV     = 7'b0000001,
        ST_MEMHI   = 7'b0000010,
        ST_MEMLO   = 7'b0000100,
        ST_WDATA   = 7'b0001000,
        ST_RESTART = 7'b0010000,
        ST_DEV2    = 7'b0100000,
        ST_RDATA   = 7'b1000000
    } stage_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [1:0]  kind;
        logic [7:0]  dev_addr;
        logic [15:0] mem_addr;
        logic        mem_addr_two;
        logic [4:0]  byte_count;
        logic [7:0]  data_byte;
        logic        sda_in;
    } in_item_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       sda_input_mode;
        logic       busy_res;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       done_res;
        logic       nack_seen;
    } res_item_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       dev;
        logic [15:0]      mem;
        logic             two;
        logic [CNT_W-1:0] count;
    } request_t;

endpackage

// ----- hdl/i2c_master_transaction_engine_core.sv -----
// ----------------------------------------------------------------------------
// I2C master transaction engine core
// Runs a whole I2C write, read, memory write or memory read transaction.
// ----------------------------------------------------------------------------
// Usage:
//   The slave-side stream carries one command per transaction: load a write
//   byte, start a transfer, or a timebase tick (sda_in is the sampled line).
//   Every command yields exactly one result on the master-side stream with
//   the SCL/SDA levels to drive, busy, read data, done and the NACK flag.
//   cfg_wr_en/cfg_wr_data set the ticks per half bit period; write it only
//   while no transfer runs and the pipe is empty.
// Timing:
//   A command is registered in the input register and its result in the result
//   register. One command is accepted every cycle unless the result side stalls;
//   the step logic updates the bus sequencer state once per command.
// Reset:
//   rst_n clears the sequencer to idle with SCL and SDA high and the
//   half period at 5 ticks. Write buffer contents are not cleared.
// Backpressure:
//   When m_axis_tready is low the result register holds and s_axis_tready
//   drops once the input register is also full; nothing is dropped.
// ----------------------------------------------------------------------------
`include "i2c_master_transaction_engine_core_assert.svh"

module i2c_master_transaction_engine_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // dev_addr[7:0], mem_addr[23:8], mem_addr_two[24], byte_count[29:25],
    // data_byte[37:30], sda_in[38], pad[39]
    input  logic [39:0] s_axis_tdata,
    // action[1:0], kind[3:2]
    input  logic [3:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // scl_out[0], sda_out[1], sda_input_mode[2], busy_res[3], rx_byte[11:4],
    // rx_valid[12], done_res[13], nack_seen[14], pad[15]
    output logic [15:0] m_axis_tdata
);
    import i2c_mte_pkg::*;

    in_item_t  s_item;
    in_item_t  q_item;
    logic      q_valid;
    logic      q_ready;
    res_item_t eng_res;
    logic      eng_valid;
    logic      eng_ready;
    res_item_t out_res;

    always_comb
    begin
        s_item.action       = s_axis_tuser[1:0];
        s_item.kind         = s_axis_tuser[3:2];
        s_item.dev_addr     = s_axis_tdata[7:0];
        s_item.mem_addr     = s_axis_tdata[23:8];
        s_item.mem_addr_two = s_axis_tdata[24];
        s_item.byte_count   = s_axis_tdata[29:25];
        s_item.data_byte    = s_axis_tdata[37:30];
        s_item.sda_in       = s_axis_tdata[38];
    end

    i2c_mte_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_item  (s_item),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    i2c_mte_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_valid  (q_valid),
        .item_ready  (q_ready),
        .item        (q_item),
        .res_valid   (eng_valid),
        .res_ready   (eng_ready),
        .res         (eng_res)
    );

    i2c_mte_out_stage u_out_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .d_valid (eng_valid),
        .d_ready (eng_ready),
        .d_res   (eng_res),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_res   (out_res)
    );

    assign m_axis_tdata = {1'b0, out_res.nack_seen, out_res.done_res, out_res.rx_valid,
                           out_res.rx_byte, out_res.busy_res, out_res.sda_input_mode,
                           out_res.sda_out, out_res.scl_out};

    // the stop condition ends the transfer on the same result
    `I2C_MTE_ASSERT_IMPL(a_done_not_busy, m_axis_tvalid && out_res.done_res, !out_res.busy_res)
    // a released SDA always reads back high
    `I2C_MTE_ASSERT_IMPL(a_release_high, m_axis_tvalid && out_res.sda_input_mode,
                         out_res.sda_out)
    // read data only on a completed byte, and never with done
    `I2C_MTE_ASSERT_IMPL(a_rx_clean, m_axis_tvalid && !out_res.rx_valid,
                         out_res.rx_byte == 8'd0)
    `I2C_MTE_ASSERT_IMPL(a_rx_busy, m_axis_tvalid && out_res.rx_valid,
                         out_res.busy_res && !out_res.done_res)
    // an engine result that is taken always shows up as a valid result
    `I2C_MTE_ASSERT_NEXT(a_out_load, eng_valid && eng_ready, m_axis_tvalid)

endmodule

// ----- hdl/i2c_mte_in_stage.sv -----
// ----------------------------------------------------------------------------
// I2C MTE input stage
// Registers one incoming transaction ahead of the engine.
// ----------------------------------------------------------------------------
module i2c_mte_in_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  i2c_mte_pkg::in_item_t s_item,
    output logic                 q_valid,
    input  logic                 q_ready,
    output i2c_mte_pkg::in_item_t q_item
);
    import i2c_mte_pkg::*;

    logic     vld_reg;
    in_item_t item_reg;

    assign s_ready = !vld_reg || q_ready;
    assign q_valid = vld_reg;
    assign q_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (s_ready)
        begin
            vld_reg <= s_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_ready && s_valid)
        begin
            item_reg <= s_item;
        end
    end

endmodule

// ----- hdl/i2c_mte_engine.sv -----
// ----------------------------------------------------------------------------
// I2C MTE engine
// Bus sequencer state, write buffer and one-step next-state logic.
// ----------------------------------------------------------------------------
module i2c_mte_engine (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [15:0]            cfg_wr_data,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  i2c_mte_pkg::in_item_t  item,
    output logic                   res_valid,
    input  logic                   res_ready,
    output i2c_mte_pkg::res_item_t res
);
    import i2c_mte_pkg::*;

    typedef struct packed {
        phase_t           phase;
        logic [1:0]       step;
        stage_t           stage;
        logic [3:0]       bit_index;
        logic [15:0]      delay_count;
        logic [7:0]       shift_bits;
        logic [CNT_W-1:0] byte_index;
        logic [CNT_W-1:0] load_index;
        logic             nack_flag;
        request_t         req;
        logic             scl;
        logic             sda;
        logic             in_mode;
    } eng_state_t;

    localparam eng_state_t ST_RESET = '{
        phase:       PH_IDLE,
        step:        2'd0,
        stage:       ST_DEV,
        bit_index:   4'd0,
        delay_count: 16'd0,
        shift_bits:  8'd0,
        byte_index:  '0,
        load_index:  '0,
        nack_flag:   1'b0,
        req:         '0,
        scl:         1'b1,
        sda:         1'b1,
        in_mode:     1'b0
    };

    eng_state_t  st_reg;
    eng_state_t  st_next;
    logic [15:0] hpt_reg;
    logic [7:0]  wbuf_reg [MAX_BYTES];

    logic        fire;
    logic [15:0] hold_ticks;
    logic        run_en;
    logic        do_proc;
    logic        do_enter;
    logic        want_wr;
    logic        want_rd;
    phase_t      ent;
    logic        buf_we;
    logic        rx_flag;
    logic        done_flag;

    assign item_ready = res_ready;
    assign res_valid  = item_valid;
    assign fire       = item_valid && item_ready;
    assign hold_ticks = (hpt_reg == 16'd0) ? 16'd1 : hpt_reg;

    always_comb
    begin
        st_next   = st_reg;
        run_en    = 1'b0;
        do_proc   = 1'b0;
        do_enter  = 1'b0;
        want_wr   = 1'b0;
        want_rd   = 1'b0;
        ent       = PH_IDLE;
        buf_we    = 1'b0;
        rx_flag   = 1'b0;
        done_flag = 1'b0;

        case (item.action)
            ACT_LOAD:
            begin
                if (st_reg.phase == PH_IDLE && st_reg.load_index < CNT_W'(MAX_BYTES))
                begin
                    buf_we             = 1'b1;
                    st_next.load_index = st_reg.load_index + 1'b1;
                end
            end
            ACT_START:
            begin
                if (st_reg.phase == PH_IDLE)
                begin
                    st_next.req.kind = item.kind;
                    st_next.req.dev  = item.dev_addr;
                    st_next.req.mem  = item.mem_addr;
                    st_next.req.two  = item.mem_addr_two;
                    if (CMP_W'(item.byte_count) > CMP_W'(MAX_BYTES))
                    begin
                        st_next.req.count = CNT_W'(MAX_BYTES);
                    end
                    else
                    begin
                        st_next.req.count = CNT_W'(item.byte_count);
                    end
                    st_next.load_index = '0;
                    st_next.byte_index = '0;
                    st_next.nack_flag  = 1'b0;
                    st_next.stage      = ST_DEV;
                    ent                = PH_START;
                    do_enter           = 1'b1;
                end
            end
            ACT_TICK:
            begin
                if (st_reg.phase != PH_IDLE)
                begin
                    if (st_reg.delay_count > 16'd1)
                    begin
                        st_next.delay_count = st_reg.delay_count - 16'd1;
                    end
                    else
                    begin
                        st_next.delay_count = 16'd0;
                        run_en              = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase

        // finish the current step of the bus sequence
        if (run_en)
        begin
            case (st_reg.phase)
                PH_START:
                begin
                    case (st_reg.step)
                        2'd0:
                        begin
                            st_next.scl = 1'b1;
                            st_next.sda = 1'b1;
                            st_next.step = 2'd1;
                            st_next.delay_count = hold_ticks;
                        end
                        2'd1:
                        begin
                            st_next.sda = 1'b0;
                            st_next.step = 2'd2;
                            st_next.delay_count = hold_ticks;
                        end
                        2'd2:
                        begin
                            st_next.scl = 1'b0;
                            st_next.step = 2'd3;
                            st_next.delay_count = hold_ticks;
                        end
                        default:
                        begin
                            do_proc = 1'b1;
                        end
                    endcase
                end
                PH_SEND:
                begin
                    case (st_reg.step)
                        2'd0:
                        begin
                            st_next.scl = 1'b0;
                            st_next.step = 2'd1;
                            st_next.delay_count = hold_ticks;
                        end
                        2'd1:
                        begin
                            st_next.sda        = st_reg.shift_bits[7];
                            st_next.scl        = 1'b1;
                            st_next.shift_bits = {st_reg.shift_bits[6:0], 1'b0};
                            st_next.bit_index  = st_reg.bit_index + 4'd1;
                            st_next.step       = 2'd2;
                            st_next.delay_count = hold_ticks;
                        end
                        default:
                        begin
                            if (st_reg.bit_index < BITS_PER_BYTE)
                            begin
                                ent      = PH_SEND;
                                do_enter = 1'b1;
                            end
                            else
                            begin
                                st_next.scl = 1'b0;
                                do_proc     = 1'b1;
                            end
                        end
                    endcase
                end
                PH_RDACK:
                begin
                    case (st_reg.step)
                        2'd0:
                        begin
                            st_next.in_mode = 1'b1;
                            st_next.step = 2'd1;
                            st_next.delay_count = hold_ticks;
                        end
                        2'd1:
                        begin
                            st_next.scl = 1'b1;
                            st_next.step = 2'd2;
                            st_next.delay_count = hold_ticks;
                        end
                        default:
                        begin
                            st_next.nack_flag = st_reg.nack_flag | item.sda_in;
                            st_next.scl       = 1'b0;
                            st_next.in_mode   = 1'b0;
                            st_next.sda       = 1'b1;
                            do_proc           = 1'b1;
                        end
                    endcase
                end
                PH_READ:
                begin
                    case (st_reg.step)
                        2'd2:
                        begin
                            st_next.shift_bits = {st_reg.shift_bits[6:0], item.sda_in};
                            st_next.scl        = 1'b0;
                            st_next.bit_index  = st_reg.bit_index + 4'd1;
                            st_next.step       = 2'd3;
                            st_next.delay_count = hold_ticks;
                        end
                        2'd3:
                        begin
                            if (st_reg.bit_index < BITS_PER_BYTE)
                            begin
                                st_next.scl = 1'b1;
                                st_next.step = 2'd2;
                                st_next.delay_count = hold_ticks;
                            end
                            else
                            begin
                                st_next.in_mode    = 1'b0;
                                st_next.sda        = 1'b1;
                                rx_flag            = 1'b1;
                                st_next.byte_index = st_reg.byte_index + 1'b1;
                                do_proc            = 1'b1;
                            end
                        end
                        default:
                        begin
                            // step 0 passes straight through to raising SCL
                            if (st_reg.step == 2'd0)
                            begin
                                st_next.in_mode   = 1'b1;
                                st_next.bit_index = 4'd0;
                            end
                            st_next.scl = 1'b1;
                            st_next.step = 2'd2;
                            st_next.delay_count = hold_ticks;
                        end
                    endcase
                end
                PH_SACK:
                begin
                    case (st_reg.step)
                        2'd0:
                        begin
                            st_next.scl = 1'b0;
                            st_next.sda = !(st_reg.byte_index < st_reg.req.count);
                            st_next.step = 2'd1;
                            st_next.delay_count = hold_ticks;
                        end
                        2'd1:
                        begin
                            st_next.scl = 1'b1;
                            st_next.step = 2'd2;
                            st_next.delay_count = hold_ticks;
                        end
                        default:
                        begin
                            st_next.scl = 1'b0;
                            st_next.sda = 1'b1;
                            do_proc     = 1'b1;
                        end
                    endcase
                end
                PH_STOP:
                begin
                    case (st_reg.step)
                        2'd0:
                        begin
                            st_next.sda = 1'b0;
                            st_next.scl = 1'b0;
                            st_next.step = 2'd1;
                            st_next.delay_count = hold_ticks;
                        end
                        2'd1:
                        begin
                            st_next.scl = 1'b1;
                            st_next.step = 2'd2;
                            st_next.delay_count = hold_ticks;
                        end
                        2'd2:
                        begin
                            st_next.sda = 1'b1;
                            st_next.step = 2'd3;
                            st_next.delay_count = hold_ticks;
                        end
                        default:
                        begin
                            st_next.phase = PH_IDLE;
                            st_next.step  = 2'd0;
                            done_flag     = 1'b1;
                        end
                    endcase
                end
                default:
                begin
                    st_next.phase = PH_IDLE;
                    st_next.step  = 2'd0;
                end
            endcase
        end

        // choose the next phase of the transaction
        if (do_proc)
        begin
            do_enter = 1'b1;
            case (st_reg.phase)
                PH_START:
                begin
                    st_next.bit_index = 4'd0;
                    ent               = PH_SEND;
                    if (st_reg.stage == ST_RESTART)
                    begin
                        st_next.shift_bits = st_reg.req.dev | ADDR_RD_BIT;
                        st_next.stage      = ST_DEV2;
                    end
                    else
                    begin
                        st_next.shift_bits = (st_reg.req.kind == KIND_READ) ?
                                             (st_reg.req.dev | ADDR_RD_BIT) :
                                             (st_reg.req.dev & ADDR_WR_MASK);
                        st_next.stage      = ST_DEV;
                    end
                end
                PH_SEND:
                begin
                    ent = PH_RDACK;
                end
                PH_RDACK:
                begin
                    case (st_reg.stage)
                        ST_DEV:
                        begin
                            case (st_reg.req.kind)
                                KIND_WRITE:
                                begin
                                    want_wr = 1'b1;
                                end
                                KIND_READ:
                                begin
                                    want_rd = 1'b1;
                                end
                                default:
                                begin
                                    ent               = PH_SEND;
                                    st_next.bit_index = 4'd0;
                                    if (st_reg.req.two)
                                    begin
                                        st_next.shift_bits = st_reg.req.mem[15:8];
                                        st_next.stage      = ST_MEMHI;
                                    end
                                    else
                                    begin
                                        st_next.shift_bits = st_reg.req.mem[7:0];
                                        st_next.stage      = ST_MEMLO;
                                    end
                                end
                            endcase
                        end
                        ST_MEMHI:
                        begin
                            ent                = PH_SEND;
                            st_next.bit_index  = 4'd0;
                            st_next.shift_bits = st_reg.req.mem[7:0];
                            st_next.stage      = ST_MEMLO;
                        end
                        ST_MEMLO:
                        begin
                            if (st_reg.req.kind == KIND_MEM_WR)
                            begin
                                want_wr = 1'b1;
                            end
                            else
                            begin
                                // repeated start, then the address with the read bit
                                st_next.stage = ST_RESTART;
                                ent           = PH_START;
                            end
                        end
                        ST_WDATA:
                        begin
                            want_wr = 1'b1;
                        end
                        default:
                        begin
                            want_rd = 1'b1;
                        end
                    endcase
                end
                PH_READ:
                begin
                    ent = PH_SACK;
                end
                PH_SACK:
                begin
                    want_rd = 1'b1;
                end
                default:
                begin
                    ent = PH_STOP;
                end
            endcase

            if (want_wr)
            begin
                if (st_next.byte_index < st_reg.req.count)
                begin
                    st_next.shift_bits = wbuf_reg[st_next.byte_index[BUF_AW-1:0]];
                    st_next.bit_index  = 4'd0;
                    st_next.byte_index = st_next.byte_index + 1'b1;
                    st_next.stage      = ST_WDATA;
                    ent                = PH_SEND;
                end
                else
                begin
                    ent = PH_STOP;
                end
            end

            if (want_rd)
            begin
                if (st_next.byte_index < st_reg.req.count)
                begin
                    st_next.stage = ST_RDATA;
                    ent           = PH_READ;
                end
                else
                begin
                    ent = PH_STOP;
                end
            end
        end

        // first step of the entered phase
        if (do_enter)
        begin
            st_next.phase = ent;
            case (ent)
                PH_START:
                begin
                    st_next.scl = 1'b1;
                    st_next.sda = 1'b1;
                    st_next.step = 2'd1;
                    st_next.delay_count = hold_ticks;
                end
                PH_SEND:
                begin
                    st_next.scl = 1'b0;
                    st_next.step = 2'd1;
                    st_next.delay_count = hold_ticks;
                end
                PH_RDACK:
                begin
                    st_next.in_mode = 1'b1;
                    st_next.step = 2'd1;
                    st_next.delay_count = hold_ticks;
                end
                PH_READ:
                begin
                    st_next.in_mode   = 1'b1;
                    st_next.bit_index = 4'd0;
                    st_next.scl       = 1'b1;
                    st_next.step      = 2'd2;
                    st_next.delay_count = hold_ticks;
                end
                PH_SACK:
                begin
                    st_next.scl = 1'b0;
                    st_next.sda = !(st_next.byte_index < st_reg.req.count);
                    st_next.step = 2'd1;
                    st_next.delay_count = hold_ticks;
                end
                PH_STOP:
                begin
                    st_next.sda = 1'b0;
                    st_next.scl = 1'b0;
                    st_next.step = 2'd1;
                    st_next.delay_count = hold_ticks;
                end
                default:
                begin
                    st_next.phase = PH_IDLE;
                    st_next.step  = 2'd0;
                end
            endcase
        end
    end

    always_comb
    begin
        res.scl_out        = st_next.scl;
        res.sda_out        = st_next.in_mode | st_next.sda;
        res.sda_input_mode = st_next.in_mode;
        res.busy_res       = (st_next.phase != PH_IDLE);
        res.rx_byte        = rx_flag ? st_next.shift_bits : 8'd0;
        res.rx_valid       = rx_flag;
        res.done_res       = done_flag;
        res.nack_seen      = st_next.nack_flag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= ST_RESET;
            hpt_reg <= HPT_RESET;
        end
        else
        begin
            if (fire)
            begin
                st_reg <= st_next;
            end
            if (cfg_wr_en)
            begin
                hpt_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && buf_we)
        begin
            wbuf_reg[st_reg.load_index[BUF_AW-1:0]] <= item.data_byte;
        end
    end

endmodule

// ----- hdl/i2c_mte_out_stage.sv -----
// ----------------------------------------------------------------------------
// I2C MTE output stage
// Result register between the engine and the master-side stream.
// ----------------------------------------------------------------------------
module i2c_mte_out_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   d_valid,
    output logic                   d_ready,
    input  i2c_mte_pkg::res_item_t d_res,
    output logic                   m_valid,
    input  logic                   m_ready,
    output i2c_mte_pkg::res_item_t m_res
);
    import i2c_mte_pkg::*;

    logic      vld_reg;
    res_item_t res_reg;

    assign d_ready = !vld_reg || m_ready;
    assign m_valid = vld_reg;
    assign m_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (d_ready)
        begin
            vld_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_ready && d_valid)
        begin
            res_reg <= d_res;
        end
    end

endmodule

// ----- bench/tb_i2c_master_transaction_engine_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master transaction engine testbench
// Streams load, start and tick commands into the core and checks every
// result against a cycle-free model of the bus sequencer kept in the bench.
// ----------------------------------------------------------------------------
module tb_i2c_master_transaction_engine_core;

    import i2c_mte_pkg::*;

    localparam logic [1:0]  ACT_NONE = 2'd3;
    localparam logic [15:0] HP_PLAN [6] = '{16'd1, 16'd2, 16'd0, 16'd3, 16'd1, 16'd4};
    localparam int          RANDOM_ITEMS = 1400;
    localparam int          MAX_REPORTS = 40;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic [3:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;

    // stimulus and checking
    in_item_t    cmd_q[$];
    res_item_t   bus_state_q[$];
    int          err_count = 0;
    int          res_seen = 0;
    int          work_items = 0;
    int          gap_left = 0;
    int          stall_left = 0;
    bit          quiet = 1'b0;
    logic        long_hold = 1'b0;

    // bus sequencer model state
    logic [15:0] hp_ticks;
    phase_t      ph;
    stage_t      stg;
    int          step_no;
    int          bit_cnt;
    int          delay_left;
    int          byte_pos;
    int          load_pos;
    int          buf_fill;
    logic [7:0]  shreg;
    logic        nack_acc;
    request_t    cur_req;
    logic [7:0]  wbuf [MAX_BYTES];
    logic        scl_q, sda_q, rel_q, rx_hit, done_hit;

    i2c_master_transaction_engine_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 clk = ~clk;

    function automatic void arm_delay();
        delay_left = (hp_ticks == 16'd0) ? 1 : int'(hp_ticks);
    endfunction

    function automatic void enter(phase_t p);
        ph = p;
        step_no = 0;
    endfunction

    function automatic void shift_out(logic [7:0] b);
        shreg = b;
        bit_cnt = 0;
        enter(PH_SEND);
    endfunction

    function automatic void next_write_or_stop();
        if (byte_pos < int'(cur_req.count) && byte_pos < MAX_BYTES)
        begin
            shift_out(wbuf[byte_pos]);
            byte_pos++;
            stg = ST_WDATA;
        end
        else
            enter(PH_STOP);
    endfunction

    function automatic void next_read_or_stop();
        if (byte_pos < int'(cur_req.count))
        begin
            stg = ST_RDATA;
            enter(PH_READ);
        end
        else
            enter(PH_STOP);
    endfunction

    // picks the next bus phase once the current one has run out
    function automatic void advance();
        case (ph)
            PH_START:
            begin
                if (stg == ST_RESTART)
                begin
                    shift_out(cur_req.dev | ADDR_RD_BIT);
                    stg = ST_DEV2;
                end
                else
                begin
                    shift_out((cur_req.kind == KIND_READ) ? (cur_req.dev | ADDR_RD_BIT)
                                                          : (cur_req.dev & ADDR_WR_MASK));
                    stg = ST_DEV;
                end
            end
            PH_SEND: enter(PH_RDACK);
            PH_RDACK:
            begin
                if (stg == ST_DEV)
                begin
                    if (cur_req.kind == KIND_WRITE)
                        next_write_or_stop();
                    else if (cur_req.kind == KIND_READ)
                        next_read_or_stop();
                    else if (cur_req.two)
                    begin
                        shift_out(cur_req.mem[15:8]);
                        stg = ST_MEMHI;
                    end
                    else
                    begin
                        shift_out(cur_req.mem[7:0]);
                        stg = ST_MEMLO;
                    end
                end
                else if (stg == ST_MEMHI)
                begin
                    shift_out(cur_req.mem[7:0]);
                    stg = ST_MEMLO;
                end
                else if (stg == ST_MEMLO)
                begin
                    if (cur_req.kind == KIND_MEM_WR)
                        next_write_or_stop();
                    else
                    begin
                        stg = ST_RESTART;
                        enter(PH_START);
                    end
                end
                else if (stg == ST_WDATA)
                    next_write_or_stop();
                else
                    next_read_or_stop();
            end
            PH_READ: enter(PH_SACK);
            PH_SACK: next_read_or_stop();
            default: enter(PH_STOP);
        endcase
    endfunction

    // runs pin steps until one of them arms a delay
    function automatic void drive_bus(logic smp);
        bit again;
        again = 1'b1;
        while (again)
        begin
            again = 1'b0;
            case (ph)
                PH_START:
                begin
                    if (step_no == 0)
                    begin
                        scl_q = 1'b1; sda_q = 1'b1; step_no = 1; arm_delay();
                    end
                    else if (step_no == 1)
                    begin
                        sda_q = 1'b0; step_no = 2; arm_delay();
                    end
                    else if (step_no == 2)
                    begin
                        scl_q = 1'b0; step_no = 3; arm_delay();
                    end
                    else
                    begin
                        advance(); again = 1'b1;
                    end
                end
                PH_SEND:
                begin
                    if (step_no == 0)
                    begin
                        scl_q = 1'b0; step_no = 1; arm_delay();
                    end
                    else if (step_no == 1)
                    begin
                        sda_q = shreg[7];
                        scl_q = 1'b1;
                        shreg = {shreg[6:0], 1'b0};
                        bit_cnt++;
                        step_no = 2;
                        arm_delay();
                    end
                    else if (bit_cnt < 8)
                    begin
                        step_no = 0; again = 1'b1;
                    end
                    else
                    begin
                        scl_q = 1'b0; advance(); again = 1'b1;
                    end
                end
                PH_RDACK:
                begin
                    if (step_no == 0)
                    begin
                        rel_q = 1'b1; step_no = 1; arm_delay();
                    end
                    else if (step_no == 1)
                    begin
                        scl_q = 1'b1; step_no = 2; arm_delay();
                    end
                    else
                    begin
                        nack_acc = nack_acc | smp;
                        scl_q = 1'b0; rel_q = 1'b0; sda_q = 1'b1;
                        advance(); again = 1'b1;
                    end
                end
                PH_READ:
                begin
                    if (step_no == 0)
                    begin
                        rel_q = 1'b1; bit_cnt = 0; step_no = 1; again = 1'b1;
                    end
                    else if (step_no == 1)
                    begin
                        scl_q = 1'b1; step_no = 2; arm_delay();
                    end
                    else if (step_no == 2)
                    begin
                        shreg = {shreg[6:0], smp};
                        scl_q = 1'b0;
                        bit_cnt++;
                        step_no = 3;
                        arm_delay();
                    end
                    else if (bit_cnt < 8)
                    begin
                        step_no = 1; again = 1'b1;
                    end
                    else
                    begin
                        rel_q = 1'b0; sda_q = 1'b1; rx_hit = 1'b1; byte_pos++;
                        advance(); again = 1'b1;
                    end
                end
                PH_SACK:
                begin
                    if (step_no == 0)
                    begin
                        // ACK all but the last byte
                        scl_q = 1'b0;
                        sda_q = (byte_pos < int'(cur_req.count)) ? 1'b0 : 1'b1;
                        step_no = 1;
                        arm_delay();
                    end
                    else if (step_no == 1)
                    begin
                        scl_q = 1'b1; step_no = 2; arm_delay();
                    end
                    else
                    begin
                        scl_q = 1'b0; sda_q = 1'b1; advance(); again = 1'b1;
                    end
                end
                PH_STOP:
                begin
                    if (step_no == 0)
                    begin
                        sda_q = 1'b0; scl_q = 1'b0; step_no = 1; arm_delay();
                    end
                    else if (step_no == 1)
                    begin
                        scl_q = 1'b1; step_no = 2; arm_delay();
                    end
                    else if (step_no == 2)
                    begin
                        sda_q = 1'b1; step_no = 3; arm_delay();
                    end
                    else
                    begin
                        enter(PH_IDLE); done_hit = 1'b1;
                    end
                end
                default: enter(PH_IDLE);
            endcase
        end
    endfunction

    function automatic res_item_t engine_step(in_item_t it);
        res_item_t r;
        rx_hit = 1'b0;
        done_hit = 1'b0;
        case (it.action)
            ACT_LOAD:
            begin
                if (ph == PH_IDLE && load_pos < MAX_BYTES)
                begin
                    wbuf[load_pos] = it.data_byte;
                    load_pos++;
                    if (load_pos > buf_fill)
                        buf_fill = load_pos;
                end
            end
            ACT_START:
            begin
                if (ph == PH_IDLE)
                begin
                    cur_req.kind = it.kind;
                    cur_req.dev = it.dev_addr;
                    cur_req.mem = it.mem_addr;
                    cur_req.two = it.mem_addr_two;
                    cur_req.count = (int'(it.byte_count) > MAX_BYTES) ? CNT_W'(MAX_BYTES)
                                                                       : CNT_W'(it.byte_count);
                    load_pos = 0;
                    byte_pos = 0;
                    nack_acc = 1'b0;
                    stg = ST_DEV;
                    enter(PH_START);
                    drive_bus(it.sda_in);
                end
            end
            ACT_TICK:
            begin
                if (ph != PH_IDLE)
                begin
                    if (delay_left > 1)
                        delay_left--;
                    else
                    begin
                        delay_left = 0;
                        drive_bus(it.sda_in);
                    end
                end
            end
            default: ;
        endcase
        r.scl_out = scl_q;
        r.sda_out = rel_q ? 1'b1 : sda_q;
        r.sda_input_mode = rel_q;
        r.busy_res = (ph != PH_IDLE);
        r.rx_byte = rx_hit ? shreg : 8'h00;
        r.rx_valid = rx_hit;
        r.done_res = done_hit;
        r.nack_seen = nack_acc;
        return r;
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        it.action = 2'($urandom_range(0, 3));
        it.kind = 2'($urandom_range(0, 3));
        it.dev_addr = 8'($urandom);
        it.mem_addr = 16'($urandom);
        it.mem_addr_two = 1'($urandom);
        it.byte_count = 5'($urandom);
        it.data_byte = 8'($urandom);
        it.sda_in = 1'($urandom);
        return it;
    endfunction

    // write counts are held to buffer entries already loaded
    function automatic logic [4:0] capped_count(logic [1:0] kind, logic [4:0] cnt, int bound);
        int sat;
        sat = (int'(cnt) > MAX_BYTES) ? MAX_BYTES : int'(cnt);
        if ((kind == KIND_WRITE || kind == KIND_MEM_WR) && sat > bound)
            return 5'(bound);
        return cnt;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        err_count++;
        // keep the log short when everything goes wrong at once
        if (err_count <= MAX_REPORTS)
            $display("%0t ns result %0d: %s got 0x%0h expected 0x%0h",
                     $time, res_seen, what, got, want);
    endtask

    task automatic set_half_period(logic [15:0] value);
        while (cmd_q.size() != 0 || bus_state_q.size() != 0 || ph != PH_IDLE)
            @(negedge clk);
        repeat (4) @(negedge clk);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        hp_ticks = value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // loads, one start, then ticks (with optional random commands) until the transaction has ended
    task automatic run_transfer(logic [1:0] kind, logic [7:0] dev, logic [15:0] mem,
                                logic two, logic [4:0] cnt, int n_loads,
                                int noise_pct, int ack_mode);
        in_item_t it;
        int fill_bound;
        int k;
        fill_bound = (buf_fill > n_loads) ? buf_fill : n_loads;
        for (k = 0; k < n_loads; k++)
        begin
            it = random_item();
            it.action = ACT_LOAD;
            cmd_q.push_back(it);
        end
        it = random_item();
        it.action = ACT_START;
        it.kind = kind;
        it.dev_addr = dev;
        it.mem_addr = mem;
        it.mem_addr_two = two;
        it.byte_count = capped_count(kind, cnt, fill_bound);
        cmd_q.push_back(it);
        work_items += n_loads + 1;
        do
        begin
            for (k = 0; k < 16; k++)
            begin
                it = random_item();
                if ($urandom_range(0, 99) < noise_pct)
                    it.byte_count = capped_count(it.kind, it.byte_count, buf_fill);
                else
                begin
                    it.action = ACT_TICK;
                    if (ack_mode == 1)
                        it.sda_in = ($urandom_range(0, 7) == 0);
                    else if (ack_mode == 2)
                        it.sda_in = 1'b0;
                    work_items++;
                end
                cmd_q.push_back(it);
            end
            while (cmd_q.size() != 0)
                @(negedge clk);
        end
        while (ph != PH_IDLE);
    endtask

    // driver: the item at the head of cmd_q is offered until taken
    always @(posedge clk)
    begin
        bit took;
        took = rst_n && s_axis_tvalid && s_axis_tready;
        if (took)
        begin
            bus_state_q.push_back(engine_step(cmd_q[0]));
            void'(cmd_q.pop_front());
        end
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (took || !s_axis_tvalid)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                gap_left = $urandom_range(0, 6);
                s_axis_tvalid <= 1'b0;
            end
            else if (cmd_q.size() != 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {1'b0, cmd_q[0].sda_in, cmd_q[0].data_byte,
                                 cmd_q[0].byte_count, cmd_q[0].mem_addr_two,
                                 cmd_q[0].mem_addr, cmd_q[0].dev_addr};
                s_axis_tuser <= {cmd_q[0].kind, cmd_q[0].action};
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // monitor: compare each result transaction with the oldest expected state
    always @(posedge clk)
    begin
        res_item_t got;
        res_item_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.scl_out = m_axis_tdata[0];
            got.sda_out = m_axis_tdata[1];
            got.sda_input_mode = m_axis_tdata[2];
            got.busy_res = m_axis_tdata[3];
            got.rx_byte = m_axis_tdata[11:4];
            got.rx_valid = m_axis_tdata[12];
            got.done_res = m_axis_tdata[13];
            got.nack_seen = m_axis_tdata[14];
            if (bus_state_q.size() == 0)
                report_mismatch("unexpected result", int'(m_axis_tdata), 0);
            else
            begin
                want = bus_state_q.pop_front();
                if (got.scl_out !== want.scl_out)
                    report_mismatch("scl_out", got.scl_out, want.scl_out);
                if (got.sda_out !== want.sda_out)
                    report_mismatch("sda_out", got.sda_out, want.sda_out);
                if (got.sda_input_mode !== want.sda_input_mode)
                    report_mismatch("sda_input_mode", got.sda_input_mode, want.sda_input_mode);
                if (got.busy_res !== want.busy_res)
                    report_mismatch("busy_res", got.busy_res, want.busy_res);
                if (got.rx_byte !== want.rx_byte)
                    report_mismatch("rx_byte", got.rx_byte, want.rx_byte);
                if (got.rx_valid !== want.rx_valid)
                    report_mismatch("rx_valid", got.rx_valid, want.rx_valid);
                if (got.done_res !== want.done_res)
                    report_mismatch("done_res", got.done_res, want.done_res);
                if (got.nack_seen !== want.nack_seen)
                    report_mismatch("nack_seen", got.nack_seen, want.nack_seen);
            end
            res_seen++;
        end
        if (!rst_n || long_hold)
            m_axis_tready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 6);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // one long receiver hold-off so the core backs up into its input
    initial
    begin
        wait (rst_n);
        repeat (400) @(posedge clk);
        long_hold <= 1'b1;
        repeat (120) @(posedge clk);
        long_hold <= 1'b0;
    end

    initial
    begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        in_item_t it;
        int plan;
        int target;
        int sel;
        int cnt;
        int n_loads;
        logic [1:0] kind;

        hp_ticks = HPT_RESET;
        ph = PH_IDLE;
        stg = ST_DEV;
        step_no = 0;
        bit_cnt = 0;
        delay_left = 0;
        byte_pos = 0;
        load_pos = 0;
        buf_fill = 0;
        shreg = '0;
        nack_acc = 1'b0;
        cur_req = '0;
        scl_q = 1'b1;
        sda_q = 1'b1;
        rel_q = 1'b0;
        rx_hit = 1'b0;
        done_hit = 1'b0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // idle: undefined action and a tick change nothing
        it = random_item();
        it.action = ACT_NONE;
        cmd_q.push_back(it);
        it = random_item();
        it.action = ACT_TICK;
        cmd_q.push_back(it);
        while (cmd_q.size() != 0)
            @(negedge clk);

        // address only, at the reset half period
        run_transfer(KIND_WRITE, 8'hFF, 16'h0000, 1'b0, 5'd0, 0, 0, 2);
        set_half_period(16'd0);
        // overfilled buffer, oversized count, commands while busy
        run_transfer(KIND_WRITE, 8'h00, 16'h0000, 1'b0, 5'd31, 17, 10, 1);
        run_transfer(KIND_READ, 8'h00, 16'hFFFF, 1'b1, 5'd3, 0, 0, 0);
        set_half_period(16'd1);
        run_transfer(KIND_MEM_WR, 8'hA5, 16'hFFFF, 1'b1, 5'd2, 2, 0, 0);
        run_transfer(KIND_MEM_RD, 8'h5A, 16'h0000, 1'b0, 5'd16, 0, 0, 1);
        run_transfer(KIND_MEM_RD, 8'h01, 16'h1234, 1'b1, 5'd0, 0, 0, 2);
        run_transfer(KIND_MEM_WR, 8'hFE, 16'h8001, 1'b0, 5'd0, 0, 5, 2);

        target = work_items;
        for (plan = 0; plan < 6; plan++)
        begin
            set_half_period(HP_PLAN[plan]);
            target += RANDOM_ITEMS / 6;
            while (work_items < target)
            begin
                kind = 2'($urandom_range(0, 3));
                sel = $urandom_range(0, 9);
                if (sel < 6)
                    cnt = $urandom_range(0, 3);
                else if (sel < 9)
                    cnt = $urandom_range(4, 16);
                else
                    cnt = $urandom_range(17, 31);
                if ($urandom_range(0, 3) == 0)
                    n_loads = $urandom_range(0, 17);
                else
                    n_loads = (cnt > MAX_BYTES) ? MAX_BYTES : cnt;
                run_transfer(kind, 8'($urandom), 16'($urandom), 1'($urandom), 5'(cnt),
                             n_loads, ($urandom_range(0, 2) == 0) ? 8 : 0,
                             $urandom_range(0, 2));
            end
        end

        // longest delay: run past two full half periods, no idling from here on
        quiet = 1'b1;
        set_half_period(16'hFFFF);
        it = random_item();
        it.action = ACT_START;
        it.kind = KIND_READ;
        it.byte_count = 5'd1;
        cmd_q.push_back(it);
        repeat (2 * 65535 + 8)
        begin
            it = random_item();
            it.action = ACT_TICK;
            it.sda_in = 1'b0;
            cmd_q.push_back(it);
        end

        while (cmd_q.size() != 0 || bus_state_q.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
